FILE: rtl/scd_pkg.sv
// scd_pkg: shared types and constants of the stall crash detector
`timescale 1ns / 1ps

package scd_pkg;

   // input operation codes
   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_REPORT  = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_ENABLE   = 3'd0,
      REG_SHADOW   = 3'd1,
      REG_DEBOUNCE = 3'd2,
      REG_FLOOR    = 3'd3,
      REG_GATE     = 3'd4
   } reg_type;

   // report statistic indexes
   localparam logic [3:0] STAT_COUNT     = 4'd0;
   localparam logic [3:0] STAT_MIN       = 4'd1;
   localparam logic [3:0] STAT_FIRST_BIN = 4'd2;
   localparam logic [3:0] STAT_TRIPS     = 4'd9;

   localparam int unsigned NUM_BINS = 7;
   localparam logic [15:0] NO_SAMPLE_MIN = 16'hffff;
   localparam logic [7:0]  DEBOUNCE_RESET = 8'd1;

   typedef logic [9:0] load_type;

   // cumulative bin upper limits (load at or below)
   localparam load_type BIN_LIMIT [NUM_BINS] = '{
      10'd0, 10'd2, 10'd5, 10'd10, 10'd20, 10'd50, 10'd100
   };

endpackage

FILE: rtl/stall_crash_detector.sv
// stall_crash_detector: motor stall detector with debounce, halt latch and shadow statistics
`timescale 1ns / 1ps

//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser operation, tdata period and load
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser stat index, tdata flags and value, tlast
//  csr     | in  | apb psel/penable       | five control registers, pready tied high
//
//  a beat is taken on the cycle it is accepted and its result sits in the output
//  register the next cycle; one sample per cycle sustained while results are taken
//  a report gives ten beats from a beat counter, so it holds req_tready low until
//  its last beat is taken; the next beat is taken in the cycle the last one leaves
//  a new beat is taken in the same cycle the pending result's last beat is taken
//  synchronous active high reset: all but the result flags reset, no clearing pass
module stall_crash_detector
   import scd_pkg::*;
#(
   parameter int STAT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [19:0] step_period, [29:20] load_value, [31:30] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] halted, [1] skipped, [2] would_trip,
                                    // [34:3] stat_value, [39:35] zero
   output logic [3:0]  rsp_tuser,   // [3:0] stat_index
   output logic        rsp_tlast,
   // control registers
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef logic [STAT_WIDTH-1:0] stat_type;

   // control registers
   logic        enable_ff;
   logic        shadow_ff;
   logic [7:0]  debounce_count_ff;
   load_type    stall_floor_ff;
   logic [19:0] velocity_gate_ff;

   // detector state
   logic [7:0]  debounce_left_ff, debounce_left_in;
   logic        halt_ff, halt_in;
   stat_type    samples_ff, samples_in;
   logic [15:0] min_load_ff, min_load_in;
   stat_type    bins_ff [NUM_BINS];
   stat_type    bins_in [NUM_BINS];
   stat_type    trips_ff, trips_in;

   // output register
   logic        rsp_valid_ff;
   logic        halted_ff, halted_in;
   logic        skipped_ff, skipped_in;
   logic        wt_ff, wt_in;
   logic        report_ff, report_in;
   logic [3:0]  idx_ff;

   logic        req_accept;
   logic        rsp_accept;
   logic        last_beat;
   logic        csr_write;
   reg_type     csr_index;
   logic [1:0]  req_op;
   logic [19:0] req_period;
   load_type    req_load;
   logic        gated_out;
   logic        stall_hit;
   logic [7:0]  debounce_dec;
   logic [31:0] stat_value;
   logic [STAT_WIDTH+31:0] stat_ext;

   assign req_op     = req_tuser;
   assign req_period = req_tdata[19:0];
   assign req_load   = req_tdata[29:20];

   assign csr_pready = 1'b1;
   assign csr_index  = reg_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // report beats run up to stat index 9; every other result is a single beat
   assign last_beat  = !report_ff || (idx_ff == STAT_TRIPS);
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign req_tready = !rsp_valid_ff || (rsp_tready && last_beat);
   assign req_accept = req_tvalid && req_tready;

   assign gated_out    = (velocity_gate_ff != 20'd0) && (req_period > velocity_gate_ff);
   assign stall_hit    = (req_load <= stall_floor_ff);
   assign debounce_dec = debounce_left_ff - 8'd1;

   // next state for one accepted beat
   always_comb begin
      debounce_left_in = debounce_left_ff;
      halt_in          = halt_ff;
      samples_in       = samples_ff;
      min_load_in      = min_load_ff;
      bins_in          = bins_ff;
      trips_in         = trips_ff;
      skipped_in       = 1'b0;
      wt_in            = 1'b0;
      report_in        = 1'b0;
      if (req_accept) begin
         unique case (req_op)
            OP_REPORT: begin
               report_in = 1'b1;
            end
            OP_RESTART: begin
               samples_in       = '0;
               min_load_in      = NO_SAMPLE_MIN;
               for (int i = 0; i < NUM_BINS; i++) begin
                  bins_in[i] = '0;
               end
               trips_in         = '0;
               halt_in          = 1'b0;
               debounce_left_in = debounce_count_ff;
            end
            OP_SAMPLE: begin
               if (!enable_ff || halt_ff) begin
                  skipped_in = 1'b1;
               end else if (gated_out) begin
                  skipped_in       = 1'b1;
                  debounce_left_in = debounce_count_ff;
               end else begin
                  if (shadow_ff) begin
                     samples_in = samples_ff + stat_type'(1);
                     if ({6'd0, req_load} < min_load_ff) begin
                        min_load_in = {6'd0, req_load};
                     end
                     for (int i = 0; i < NUM_BINS; i++) begin
                        if (req_load <= BIN_LIMIT[i]) begin
                           bins_in[i] = bins_ff[i] + stat_type'(1);
                        end
                     end
                  end
                  if (stall_hit) begin
                     if (debounce_dec == 8'd0) begin
                        if (shadow_ff) begin
                           trips_in = trips_ff + stat_type'(1);
                           wt_in    = 1'b1;
                        end else begin
                           halt_in = 1'b1;
                        end
                        debounce_left_in = debounce_count_ff;
                     end else begin
                        debounce_left_in = debounce_dec;
                     end
                  end else begin
                     debounce_left_in = debounce_count_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      // debounce count write also reloads the counter
      if (csr_write && (csr_index == REG_DEBOUNCE)) begin
         debounce_left_in = csr_pwdata[7:0];
      end
      halted_in = halt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         shadow_ff         <= 1'b0;
         debounce_count_ff <= DEBOUNCE_RESET;
         stall_floor_ff    <= '0;
         velocity_gate_ff  <= '0;
         debounce_left_ff  <= DEBOUNCE_RESET;
         halt_ff           <= 1'b0;
         samples_ff        <= '0;
         min_load_ff       <= NO_SAMPLE_MIN;
         for (int i = 0; i < NUM_BINS; i++) begin
            bins_ff[i] <= '0;
         end
         trips_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         report_ff         <= 1'b0;
         idx_ff            <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_ENABLE:   enable_ff         <= csr_pwdata[0];
               REG_SHADOW:   shadow_ff         <= csr_pwdata[0];
               REG_DEBOUNCE: debounce_count_ff <= csr_pwdata[7:0];
               REG_FLOOR:    stall_floor_ff    <= csr_pwdata[9:0];
               REG_GATE:     velocity_gate_ff  <= csr_pwdata[19:0];
               default: begin
               end
            endcase
         end
         debounce_left_ff <= debounce_left_in;
         halt_ff          <= halt_in;
         samples_ff       <= samples_in;
         min_load_ff      <= min_load_in;
         bins_ff          <= bins_in;
         trips_ff         <= trips_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
            report_ff    <= report_in;
            idx_ff       <= STAT_COUNT;
         end else if (rsp_accept) begin
            if (last_beat) begin
               rsp_valid_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 4'd1;
            end
         end
      end
   end

   // result flags, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         halted_ff  <= halted_in;
         skipped_ff <= skipped_in;
         wt_ff      <= wt_in;
      end
   end

   // report value read from live statistics; nothing changes them during a report
   always_comb begin
      case (idx_ff)
         STAT_COUNT: stat_ext = {32'd0, samples_ff};
         STAT_TRIPS: stat_ext = {32'd0, trips_ff};
         STAT_MIN:   stat_ext = (STAT_WIDTH+32)'(min_load_ff);
         default:    stat_ext = {32'd0, bins_ff[idx_ff[2:0] - 3'(STAT_FIRST_BIN)]};
      endcase
      stat_value = report_ff ? stat_ext[31:0] : 32'd0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_beat;
   assign rsp_tuser  = report_ff ? idx_ff : STAT_COUNT;
   assign rsp_tdata  = {5'd0, stat_value, wt_ff, skipped_ff, halted_ff};

   // register readback
   always_comb begin
      case (csr_index)
         REG_ENABLE:   csr_prdata = {31'd0, enable_ff};
         REG_SHADOW:   csr_prdata = {31'd0, shadow_ff};
         REG_DEBOUNCE: csr_prdata = {24'd0, debounce_count_ff};
         REG_FLOOR:    csr_prdata = {22'd0, stall_floor_ff};
         REG_GATE:     csr_prdata = {12'd0, velocity_gate_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

`ifndef SYNTHESIS
   // a halted block never reports a shadow trip
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && wt_ff) |-> !halted_ff)
      else $error("would_trip beat with halt latch set");

   // report beat counter stays within the statistics
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && report_ff) |-> (idx_ff <= STAT_TRIPS))
      else $error("report index overran");

   // a new beat only enters when no result is pending or its last beat is being taken
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!rsp_valid_ff || (rsp_tready && last_beat)))
      else $error("beat taken while report pending");

   // restart clears the latch
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_RESTART)) |=> !halt_ff)
      else $error("halt latch survived restart");

   // minimum holds a load reading or the empty mark
   assert property (@(posedge clock) disable iff (reset)
      (min_load_ff <= 16'd1023) || (min_load_ff == NO_SAMPLE_MIN))
      else $error("minimum out of range");
`endif

endmodule

FILE: dv/stall_crash_detector_tb.sv
// stall_crash_detector_tb: self-checking stream testbench of the stall crash detector
`timescale 1ns / 1ps

module stall_crash_detector_tb;
   import scd_pkg::*;

   // operation code with no defined behavior, must answer with one plain beat
   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam int NUM_STATS = NUM_BINS + 3;
   localparam int HOLD_OFF_CYCLES = 80;

   // one request beat: tuser carries op, tdata carries period and load
   typedef struct packed {
      logic [1:0]  op;
      logic [19:0] period;
      load_type    load;
   } command_type;

   // one response beat, field by field
   typedef struct packed {
      logic        halted;
      logic        skipped;
      logic        would_trip;
      logic [3:0]  index;
      logic [31:0] value;
      logic        last;
   } detector_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   stall_crash_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // stimulus waiting for the driver, and results the detector still owes us
   command_type         command_queue[$];
   detector_result_type outputs_due[$];
   command_type         offered_cmd;

   // idling knobs in percent, changed only between phases
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic pressure_armed = 1'b0;
   logic receiver_held = 1'b0;
   int  mismatch_count = 0;

   // predictor copy of the control registers
   logic        armed;
   logic        shadow_on;
   logic [7:0]  debounce_set;
   load_type    floor_set;
   logic [19:0] gate_set;

   // predictor copy of the detector state
   logic [7:0]  debounce_left;
   logic        halt_latched;
   logic [31:0] sample_total;
   logic [15:0] lowest_load;
   logic [31:0] bin_total [NUM_BINS];
   logic [31:0] trip_total;

   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop in case the handshakes hang
   initial begin
      #5_000_000;
      $display("stall_crash_detector_tb: errors");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < 100)
         $display("mismatch %s: got %0h want %0h at %0t ns", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic clear_statistics();
      sample_total = '0;
      lowest_load = NO_SAMPLE_MIN;
      for (int b = 0; b < NUM_BINS; b++) bin_total[b] = '0;
      trip_total = '0;
   endtask

   // expected beats for one accepted request, updating the predicted state
   task automatic detector_step(input command_type c);
      detector_result_type r;
      logic [7:0] next_left;
      r = '0;
      r.last = 1'b1;
      if (c.op == OP_REPORT) begin
         // ten statistic beats, last one on the trip counter
         for (int k = 0; k < NUM_STATS; k++) begin
            r = '0;
            r.halted = halt_latched;
            r.index = k[3:0];
            if (k == STAT_COUNT) r.value = sample_total;
            else if (k == STAT_MIN) r.value = {16'h0000, lowest_load};
            else if (k == STAT_TRIPS) r.value = trip_total;
            else r.value = bin_total[k - STAT_FIRST_BIN];
            r.last = (k == STAT_TRIPS);
            outputs_due.push_back(r);
         end
         return;
      end
      if (c.op == OP_RESTART) begin
         clear_statistics();
         halt_latched = 1'b0;
         debounce_left = debounce_set;
         outputs_due.push_back(r);
         return;
      end
      if (c.op == OP_UNDEFINED) begin
         r.halted = halt_latched;
         outputs_due.push_back(r);
         return;
      end
      // plain sample from here on
      if (!armed || halt_latched) begin
         r.halted = halt_latched;
         r.skipped = 1'b1;
         outputs_due.push_back(r);
         return;
      end
      if (gate_set != 0 && c.period > gate_set) begin
         debounce_left = debounce_set;
         r.halted = halt_latched;
         r.skipped = 1'b1;
         outputs_due.push_back(r);
         return;
      end
      if (shadow_on) begin
         sample_total++;
         if ({6'b0, c.load} < lowest_load) lowest_load = {6'b0, c.load};
         for (int b = 0; b < NUM_BINS; b++)
            if (c.load <= BIN_LIMIT[b]) bin_total[b]++;
      end
      if (c.load <= floor_set) begin
         // counter wraps, so a debounce of zero needs 256 stall samples
         next_left = debounce_left - 8'd1;
         if (next_left == 8'd0) begin
            if (shadow_on) begin
               trip_total++;
               r.would_trip = 1'b1;
            end else begin
               halt_latched = 1'b1;
            end
            debounce_left = debounce_set;
         end else begin
            debounce_left = next_left;
         end
      end else begin
         debounce_left = debounce_set;
      end
      r.halted = halt_latched;
      outputs_due.push_back(r);
   endtask

   // request driver: holds a beat until taken, pulls the next one from the queue
   always @(posedge clock) begin : drive_requests
      command_type next_cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) detector_step(offered_cmd);
         if (!req_tvalid || req_tready) begin
            if (command_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_cmd = command_queue.pop_front();
               offered_cmd = next_cmd;
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, next_cmd.load, next_cmd.period};
               req_tuser <= next_cmd.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compares each taken beat with the oldest one owed
   always @(posedge clock) begin : watch_results
      detector_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outputs_due.size() == 0) begin
               flag_mismatch("beat with nothing owed", rsp_tdata[34:3], 32'h0);
            end else begin
               want = outputs_due.pop_front();
               if (rsp_tdata[0] !== want.halted)
                  flag_mismatch("halted", 32'(rsp_tdata[0]), 32'(want.halted));
               if (rsp_tdata[1] !== want.skipped)
                  flag_mismatch("skipped", 32'(rsp_tdata[1]), 32'(want.skipped));
               if (rsp_tdata[2] !== want.would_trip)
                  flag_mismatch("would_trip", 32'(rsp_tdata[2]), 32'(want.would_trip));
               if (rsp_tuser !== want.index)
                  flag_mismatch("stat_index", 32'(rsp_tuser), 32'(want.index));
               if (rsp_tdata[34:3] !== want.value)
                  flag_mismatch("stat_value", rsp_tdata[34:3], want.value);
               if (rsp_tlast !== want.last)
                  flag_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            end
         end
         rsp_tready <= !receiver_held && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off so the output fills and req_tready drops
   initial begin : hold_off_receiver
      wait (pressure_armed);
      @(posedge clock);
      receiver_held <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      receiver_held <= 1'b0;
   end

   // apb write: setup beat, access beat, register taken on the access edge
   task automatic write_register(input reg_type r, input logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (r)
         REG_ENABLE:   armed = v[0];
         REG_SHADOW:   shadow_on = v[0];
         REG_DEBOUNCE: begin
            debounce_set = v[7:0];
            debounce_left = v[7:0];
         end
         REG_FLOOR:    floor_set = v[9:0];
         REG_GATE:     gate_set = v[19:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic en, input logic sh, input logic [7:0] deb,
                            input load_type flr, input logic [19:0] gate);
      write_register(REG_ENABLE, {31'b0, en});
      write_register(REG_SHADOW, {31'b0, sh});
      write_register(REG_DEBOUNCE, {24'b0, deb});
      write_register(REG_FLOOR, {22'b0, flr});
      write_register(REG_GATE, {12'b0, gate});
   endtask

   // block is idle once nothing is queued, offered or owed
   // checked at the falling edge so the driver's updates have settled
   task automatic wait_quiet();
      @(negedge clock);
      while (command_queue.size() != 0 || req_tvalid || outputs_due.size() != 0
             || rsp_tvalid)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic command_type make_command(input logic [1:0] op,
                                                input logic [19:0] period,
                                                input load_type load);
      command_type c;
      c.op = op;
      c.period = period;
      c.load = load;
      return c;
   endfunction

   // mostly gated-in samples near the floor, some reports and restarts
   function automatic command_type random_command();
      command_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 7) c.op = OP_REPORT;
      else if (pick < 14) c.op = OP_RESTART;
      else c.op = OP_SAMPLE;
      if (gate_set != 0 && $urandom_range(0, 4) != 0)
         c.period = 20'($urandom_range(0, gate_set));
      else
         c.period = 20'($urandom());
      if ($urandom_range(0, 1) == 1)
         c.load = 10'($urandom_range(0, floor_set));
      else
         c.load = 10'($urandom());
      return c;
   endfunction

   task automatic random_phase(input int count, input int send_pct, input int recv_pct,
                               input logic pressure);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < count; n++) command_queue.push_back(random_command());
      if (pressure) pressure_armed = 1'b1;
      wait_quiet();
   endtask

   initial begin : run_test
      // predictor starts from the reset state
      armed = 1'b0;
      shadow_on = 1'b0;
      debounce_set = DEBOUNCE_RESET;
      floor_set = '0;
      gate_set = '0;
      debounce_left = DEBOUNCE_RESET;
      halt_latched = 1'b0;
      clear_statistics();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disarmed at reset: sample ignored, empty statistics, undefined op
      command_queue.push_back(make_command(OP_SAMPLE, 20'h0, 10'd0));
      command_queue.push_back(make_command(OP_REPORT, 20'h0, 10'd0));
      command_queue.push_back(make_command(OP_UNDEFINED, 20'h0, 10'd0));
      wait_quiet();

      // shadow mode: gate edges, bin edges, a would-trip and a restart
      configure(1'b1, 1'b1, 8'd2, 10'd5, 20'd1000);
      command_queue.push_back(make_command(OP_SAMPLE, 20'd1001, 10'd0));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd1000, 10'd0));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd0, 10'd1023));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd0, 10'd5));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd0, 10'd0));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd7, 10'd2));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd7, 10'd20));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd7, 10'd50));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd7, 10'd100));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd7, 10'd101));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd7, 10'd10));
      command_queue.push_back(make_command(OP_SAMPLE, 20'hfffff, 10'd0));
      command_queue.push_back(make_command(OP_REPORT, 20'h0, 10'd0));
      command_queue.push_back(make_command(OP_RESTART, 20'h0, 10'd0));
      command_queue.push_back(make_command(OP_REPORT, 20'h0, 10'd0));
      wait_quiet();

      // normal mode, gate off, top floor: halt, halted skip, held report
      configure(1'b1, 1'b0, 8'd1, 10'd1023, 20'd0);
      command_queue.push_back(make_command(OP_SAMPLE, 20'hfffff, 10'd1023));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd3, 10'd0));
      command_queue.push_back(make_command(OP_REPORT, 20'h0, 10'd0));
      command_queue.push_back(make_command(OP_RESTART, 20'h0, 10'd0));
      command_queue.push_back(make_command(OP_SAMPLE, 20'd3, 10'd0));
      command_queue.push_back(make_command(OP_RESTART, 20'h0, 10'd0));
      command_queue.push_back(make_command(OP_UNDEFINED, 20'hfffff, 10'd1023));
      wait_quiet();

      // random phases across settings and idling patterns
      configure(1'b1, 1'b1, 8'd3, 10'd50, 20'd0);
      random_phase(45, 0, 0, 1'b0);
      configure(1'b1, 1'b0, 8'd2, 10'd300, 20'hfffff);
      random_phase(40, 79, 0, 1'b0);
      // sender keeps offering while the receiver is held off
      configure(1'b1, 1'b1, 8'd255, 10'd0, 20'd500);
      random_phase(40, 0, 79, 1'b1);
      // debounce of zero wraps the counter
      configure(1'b1, 1'b1, 8'd0, 10'd200, 20'd300000);
      random_phase(40, 27, 27, 1'b0);
      configure(1'b0, 1'b1, 8'd1, 10'd40, 20'd0);
      random_phase(10, 0, 0, 1'b0);
      configure(1'b1, 1'b0, 8'd1, 10'd8, 20'd2000);
      random_phase(45, 79, 79, 1'b0);

      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("stall_crash_detector_tb: clean");
      else
         $display("stall_crash_detector_tb: errors");
      $finish;
   end

endmodule
